// ----- design/gcdc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcdc_pkg
// shared types, constants and calendar helpers for the gregorian day counter
// ----------------------------------------------------------------------------
package gcdc_pkg;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int SERIAL_W = 22;
   localparam int OFFSET_W = 16;
   localparam int STATUS_W = 2;
   localparam int OP_W     = 2;
   localparam int YMOD_W   = 9;   // year modulo 400
   localparam int Q100_W   = 8;   // year / 100 for years up to 16383

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;

   localparam logic [SERIAL_W-1:0] MAX_SERIAL = 22'd3652058;
   localparam logic [YEAR_W-1:0]   MAX_YEAR   = 14'd9999;
   localparam logic [MONTH_W-1:0]  DECEMBER   = 4'd12;
   localparam logic [MONTH_W-1:0]  JANUARY    = 4'd1;
   localparam logic [MONTH_W-1:0]  FEBRUARY   = 4'd2;
   localparam logic [YMOD_W-1:0]   LAST_YMOD  = 9'd399;

   // x / 100 == (x * 5243) >> 19 for every x below 16384
   localparam int RECIP_100   = 5243;
   localparam int RECIP_SHIFT = 19;
   localparam int RECIP_W     = 13;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD   = 2'd0,
      OP_NEXT   = 2'd1,
      OP_PREV   = 2'd2,
      OP_OFFSET = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_RANGE   = 2'd2
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic       capture;      // latch the request fields
      logic       load_mul;     // reciprocal and year products
      logic       load_sum;     // base day count and year modulo 400
      logic       load_commit;  // write the loaded date if it checked out
      logic       step_en;      // move one day
      logic       step_back;    // direction of that move
      logic       cnt_dec;      // one offset day used up
      logic       rsp_write;    // load the output register
      status_type rsp_status;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic at_min;
      logic at_max;
      logic cnt_zero;
      logic dir_back;
      logic load_ok;
   } dp_status_type;

   function automatic logic is_leap(input logic [YMOD_W-1:0] ymod);
      is_leap = (ymod[1:0] == 2'd0) && (ymod != 9'd100) && (ymod != 9'd200)
                && (ymod != 9'd300);
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
      case (month) inside
         4'd2:                                   month_len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:                month_len = 5'd30;
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
         default:                                month_len = 5'd0;
      endcase
   endfunction

   // days in the months before this one, common year
   function automatic logic [8:0] month_cum(input logic [MONTH_W-1:0] month);
      case (month)
         4'd1:    month_cum = 9'd0;
         4'd2:    month_cum = 9'd31;
         4'd3:    month_cum = 9'd59;
         4'd4:    month_cum = 9'd90;
         4'd5:    month_cum = 9'd120;
         4'd6:    month_cum = 9'd151;
         4'd7:    month_cum = 9'd181;
         4'd8:    month_cum = 9'd212;
         4'd9:    month_cum = 9'd243;
         4'd10:   month_cum = 9'd273;
         4'd11:   month_cum = 9'd304;
         4'd12:   month_cum = 9'd334;
         default: month_cum = 9'd0;
      endcase
   endfunction

endpackage

// ----- design/gcdc_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcdc_datapath
// date and day number registers, load arithmetic, day stepper, output register
// ----------------------------------------------------------------------------
module gcdc_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [gcdc_pkg::YEAR_W-1:0]           load_year,
   input  logic [gcdc_pkg::MONTH_W-1:0]          load_month,
   input  logic [gcdc_pkg::DAY_W-1:0]            load_day,
   input  logic signed [gcdc_pkg::OFFSET_W-1:0]  offset_days,
   input  gcdc_pkg::dp_cmd_type                  cmd,
   output gcdc_pkg::dp_status_type               stat,
   output logic [gcdc_pkg::YEAR_W-1:0]           rsp_year,
   output logic [gcdc_pkg::MONTH_W-1:0]          rsp_month,
   output logic [gcdc_pkg::DAY_W-1:0]            rsp_day,
   output logic [gcdc_pkg::SERIAL_W-1:0]         rsp_serial,
   output gcdc_pkg::status_type                  rsp_status
);

   localparam int PROD_W = gcdc_pkg::YEAR_W + gcdc_pkg::RECIP_W;
   localparam int BASE_W = gcdc_pkg::SERIAL_W + 1;

   // current date
   logic [gcdc_pkg::YEAR_W-1:0]   year_ff, year_in;
   logic [gcdc_pkg::MONTH_W-1:0]  month_ff, month_in;
   logic [gcdc_pkg::DAY_W-1:0]    day_ff, day_in;
   logic [gcdc_pkg::SERIAL_W-1:0] serial_ff, serial_in;
   logic [gcdc_pkg::YMOD_W-1:0]   ymod_ff, ymod_in;

   // captured request and offset counter
   logic [gcdc_pkg::YEAR_W-1:0]   ly_ff;
   logic [gcdc_pkg::MONTH_W-1:0]  lm_ff;
   logic [gcdc_pkg::DAY_W-1:0]    ld_ff;
   logic [gcdc_pkg::OFFSET_W-1:0] cnt_ff, cnt_in;
   logic                          dir_ff;

   // load pipeline
   logic [gcdc_pkg::Q100_W-1:0]   qy100_ff, qp100_ff;
   logic [BASE_W-1:0]             p365_ff, base_ff;
   logic [gcdc_pkg::YMOD_W-1:0]   lmod_ff;

   // output register
   logic [gcdc_pkg::YEAR_W-1:0]   rsp_year_ff;
   logic [gcdc_pkg::MONTH_W-1:0]  rsp_month_ff;
   logic [gcdc_pkg::DAY_W-1:0]    rsp_day_ff;
   logic [gcdc_pkg::SERIAL_W-1:0] rsp_serial_ff;
   gcdc_pkg::status_type          rsp_status_ff;

   logic [gcdc_pkg::YEAR_W-1:0]   p_w;
   logic [PROD_W-1:0]             qy_prod, qp_prod;
   logic [gcdc_pkg::YEAR_W-1:0]   lmod_w;
   logic [BASE_W-1:0]             base_w;
   logic                          leap_ld, leap_cur, load_ok;
   logic [gcdc_pkg::SERIAL_W-1:0] serial_ld;
   logic [gcdc_pkg::DAY_W-1:0]    dim_cur;
   logic [gcdc_pkg::MONTH_W-1:0]  month_prev;

   // load arithmetic
   always_comb begin
      p_w     = ly_ff - 14'd1;
      qy_prod = PROD_W'(ly_ff) * PROD_W'(gcdc_pkg::RECIP_100);
      qp_prod = PROD_W'(p_w) * PROD_W'(gcdc_pkg::RECIP_100);
      lmod_w  = ly_ff - 14'({8'd0, qy100_ff[7:2]} * 14'd400);
      base_w  = p365_ff + BASE_W'(p_w[13:2]) - BASE_W'(qp100_ff)
                + BASE_W'(qp100_ff[7:2]);
      leap_ld = gcdc_pkg::is_leap(lmod_ff);
      load_ok = (ly_ff != 14'd0) && (ly_ff <= gcdc_pkg::MAX_YEAR)
                && (lm_ff != 4'd0) && (lm_ff <= gcdc_pkg::DECEMBER)
                && (ld_ff != 5'd0) && (ld_ff <= gcdc_pkg::month_len(lm_ff, leap_ld));
      serial_ld = base_ff[gcdc_pkg::SERIAL_W-1:0]
                  + gcdc_pkg::SERIAL_W'(gcdc_pkg::month_cum(lm_ff))
                  + gcdc_pkg::SERIAL_W'(leap_ld && (lm_ff > gcdc_pkg::FEBRUARY))
                  + gcdc_pkg::SERIAL_W'(ld_ff) - 22'd1;
   end

   // next state of the date
   always_comb begin
      leap_cur   = gcdc_pkg::is_leap(ymod_ff);
      dim_cur    = gcdc_pkg::month_len(month_ff, leap_cur);
      month_prev = month_ff - 4'd1;
      year_in    = year_ff;
      month_in   = month_ff;
      day_in     = day_ff;
      serial_in  = serial_ff;
      ymod_in    = ymod_ff;
      if (cmd.step_en && !cmd.step_back) begin
         serial_in = serial_ff + 22'd1;
         if (day_ff < dim_cur) begin
            day_in = day_ff + 5'd1;
         end else begin
            day_in = 5'd1;
            if (month_ff == gcdc_pkg::DECEMBER) begin
               month_in = gcdc_pkg::JANUARY;
               year_in  = year_ff + 14'd1;
               ymod_in  = (ymod_ff == gcdc_pkg::LAST_YMOD) ? 9'd0 : ymod_ff + 9'd1;
            end else begin
               month_in = month_ff + 4'd1;
            end
         end
      end else if (cmd.step_en) begin
         serial_in = serial_ff - 22'd1;
         if (day_ff > 5'd1) begin
            day_in = day_ff - 5'd1;
         end else if (month_ff == gcdc_pkg::JANUARY) begin
            // december is 31 days whatever the year
            month_in = gcdc_pkg::DECEMBER;
            day_in   = 5'd31;
            year_in  = year_ff - 14'd1;
            ymod_in  = (ymod_ff == 9'd0) ? gcdc_pkg::LAST_YMOD : ymod_ff - 9'd1;
         end else begin
            month_in = month_prev;
            day_in   = gcdc_pkg::month_len(month_prev, leap_cur);
         end
      end else if (cmd.load_commit && load_ok) begin
         year_in   = ly_ff;
         month_in  = lm_ff;
         day_in    = ld_ff;
         serial_in = serial_ld;
         ymod_in   = lmod_ff;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.capture) begin
         cnt_in = offset_days[gcdc_pkg::OFFSET_W-1] ? (~offset_days + 16'd1) : offset_days;
      end else if (cmd.cnt_dec) begin
         cnt_in = cnt_ff - 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff   <= 14'd1;
         month_ff  <= gcdc_pkg::JANUARY;
         day_ff    <= 5'd1;
         serial_ff <= 22'd0;
         ymod_ff   <= 9'd1;
      end else begin
         year_ff   <= year_in;
         month_ff  <= month_in;
         day_ff    <= day_in;
         serial_ff <= serial_in;
         ymod_ff   <= ymod_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      if (cmd.capture) begin
         ly_ff  <= load_year;
         lm_ff  <= load_month;
         ld_ff  <= load_day;
         dir_ff <= offset_days[gcdc_pkg::OFFSET_W-1];
      end
      if (cmd.load_mul) begin
         qy100_ff <= qy_prod[gcdc_pkg::RECIP_SHIFT +: gcdc_pkg::Q100_W];
         qp100_ff <= qp_prod[gcdc_pkg::RECIP_SHIFT +: gcdc_pkg::Q100_W];
         p365_ff  <= BASE_W'(p_w) * BASE_W'(365);
      end
      if (cmd.load_sum) begin
         lmod_ff <= lmod_w[gcdc_pkg::YMOD_W-1:0];
         base_ff <= base_w;
      end
      if (cmd.rsp_write) begin
         rsp_year_ff   <= year_in;
         rsp_month_ff  <= month_in;
         rsp_day_ff    <= day_in;
         rsp_serial_ff <= serial_in;
         rsp_status_ff <= cmd.rsp_status;
      end
   end

   assign stat.at_min   = (serial_ff == 22'd0);
   assign stat.at_max   = (serial_ff >= gcdc_pkg::MAX_SERIAL);
   assign stat.cnt_zero = (cnt_ff == 16'd0);
   assign stat.dir_back = dir_ff;
   assign stat.load_ok  = load_ok;

   assign rsp_year   = rsp_year_ff;
   assign rsp_month  = rsp_month_ff;
   assign rsp_day    = rsp_day_ff;
   assign rsp_serial = rsp_serial_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// ----- design/gcdc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcdc_ctrl
// request sequencer: load pipeline, day-by-day offset walk, output handshake
// ----------------------------------------------------------------------------
module gcdc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  gcdc_pkg::op_type        req_op,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output gcdc_pkg::dp_cmd_type    cmd,
   input  gcdc_pkg::dp_status_type stat
);

   typedef enum logic [2:0] {
      IDLE,
      LOAD_MUL,
      LOAD_SUM,
      LOAD_COMMIT,
      STEP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free, limit;

   always_comb begin
      slot_free  = !rsp_valid_ff || rsp_tready;
      limit      = stat.dir_back ? stat.at_min : stat.at_max;
      cmd        = '0;
      state_in   = state_ff;
      req_tready = 1'b0;
      case (state_ff)
         IDLE: begin
            // single-day steps answer at once and need the output slot
            req_tready = slot_free || (req_op == gcdc_pkg::OP_LOAD)
                         || (req_op == gcdc_pkg::OP_OFFSET);
            if (req_tvalid && req_tready) begin
               case (req_op)
                  gcdc_pkg::OP_LOAD: begin
                     cmd.capture = 1'b1;
                     state_in    = LOAD_MUL;
                  end
                  gcdc_pkg::OP_OFFSET: begin
                     cmd.capture = 1'b1;
                     state_in    = STEP;
                  end
                  gcdc_pkg::OP_NEXT: begin
                     cmd.rsp_write = 1'b1;
                     if (stat.at_max) begin
                        cmd.rsp_status = gcdc_pkg::ST_RANGE;
                     end else begin
                        cmd.step_en = 1'b1;
                     end
                  end
                  gcdc_pkg::OP_PREV: begin
                     cmd.rsp_write = 1'b1;
                     cmd.step_back = 1'b1;
                     if (stat.at_min) begin
                        cmd.rsp_status = gcdc_pkg::ST_RANGE;
                     end else begin
                        cmd.step_en = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         LOAD_MUL: begin
            cmd.load_mul = 1'b1;
            state_in     = LOAD_SUM;
         end
         LOAD_SUM: begin
            cmd.load_sum = 1'b1;
            state_in     = LOAD_COMMIT;
         end
         LOAD_COMMIT: begin
            if (slot_free) begin
               cmd.load_commit = 1'b1;
               cmd.rsp_write   = 1'b1;
               cmd.rsp_status  = stat.load_ok ? gcdc_pkg::ST_OK : gcdc_pkg::ST_INVALID;
               state_in        = IDLE;
            end
         end
         STEP: begin
            if (stat.cnt_zero || limit) begin
               // landing exactly on a limit is still a clean finish
               if (slot_free) begin
                  cmd.rsp_write  = 1'b1;
                  cmd.rsp_status = stat.cnt_zero ? gcdc_pkg::ST_OK : gcdc_pkg::ST_RANGE;
                  state_in       = IDLE;
               end
            end else begin
               cmd.step_en   = 1'b1;
               cmd.step_back = stat.dir_back;
               cmd.cnt_dec   = 1'b1;
            end
         end
         default: state_in = IDLE;
      endcase
      rsp_valid_in = cmd.rsp_write || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- design/gregorian_calendar_day_counter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_calendar_day_counter
// proleptic gregorian date register with serial day number, load and stepping
// ----------------------------------------------------------------------------
//
//  channel | direction | fields (lowest bits first)
//  --------+-----------+---------------------------------------------------------
//  req     | in        | tuser: op; tdata: load_year, load_month, load_day,
//          |           |        offset_days
//  rsp     | out       | tdata: cur_year, cur_month, cur_day, day_number, status
//
//  next / previous day: result registered at accepting edge, one per cycle while
//    the output register is free; load: result after multiply, sum, check/commit
//  offset of n days: one day per cycle through the shared stepper, result once
//    all n days are walked, earlier when a calendar limit stops it
//  synchronous reset returns the date to 0001-01-01, day number 0
//  a waiting result holds the output register; a load or an offset is taken
//    meanwhile and waits in its last cycle until the register is free
//
module gregorian_calendar_day_counter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // load_year[13:0], load_month[17:14], load_day[22:18], offset_days[38:23], pad
   input  logic [gcdc_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // op[1:0]
   input  logic [gcdc_pkg::OP_W-1:0]            req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // cur_year[13:0], cur_month[17:14], cur_day[22:18], day_number[44:23],
   // status[46:45], pad
   output logic [gcdc_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   gcdc_pkg::dp_cmd_type          cmd;
   gcdc_pkg::dp_status_type       stat;
   gcdc_pkg::op_type              req_op;

   logic [gcdc_pkg::YEAR_W-1:0]          load_year;
   logic [gcdc_pkg::MONTH_W-1:0]         load_month;
   logic [gcdc_pkg::DAY_W-1:0]           load_day;
   logic signed [gcdc_pkg::OFFSET_W-1:0] offset_days;

   logic [gcdc_pkg::YEAR_W-1:0]   cur_year;
   logic [gcdc_pkg::MONTH_W-1:0]  cur_month;
   logic [gcdc_pkg::DAY_W-1:0]    cur_day;
   logic [gcdc_pkg::SERIAL_W-1:0] day_number;
   gcdc_pkg::status_type          status;

   // request unpacking
   assign req_op      = gcdc_pkg::op_type'(req_tuser);
   assign load_year   = req_tdata[13:0];
   assign load_month  = req_tdata[17:14];
   assign load_day    = req_tdata[22:18];
   assign offset_days = req_tdata[38:23];

   // sequencer: owns the handshakes and the output valid flag
   gcdc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_op),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   // date registers, load arithmetic, stepper and output register
   gcdc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .load_year   (load_year),
      .load_month  (load_month),
      .load_day    (load_day),
      .offset_days (offset_days),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_year    (cur_year),
      .rsp_month   (cur_month),
      .rsp_day     (cur_day),
      .rsp_serial  (day_number),
      .rsp_status  (status)
   );

   // result packing, one zero bit of padding on top
   assign rsp_tdata = {1'b0, status, day_number, cur_day, cur_month, cur_year};

endmodule

// ----- design/gcdc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcdc_checker
// port-level checks on the gregorian day counter, bound to the top level
// ----------------------------------------------------------------------------
module gcdc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [gcdc_pkg::OP_W-1:0]        req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [gcdc_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // no result during or straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // results always carry a month in range, a nonzero day and a known status
   a_rsp_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[17:14] != 4'd0)
                     && (rsp_tdata[17:14] <= gcdc_pkg::DECEMBER)
                     && (rsp_tdata[22:18] != 5'd0)
                     && (rsp_tdata[46:45] <= gcdc_pkg::ST_RANGE)
                     && (rsp_tdata[47] == 1'b0))
      else $error("malformed result");

   a_serial_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[44:23] <= gcdc_pkg::MAX_SERIAL)
      else $error("day number out of range");

   // a single-day step answers on the very next cycle
   a_step_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready
      && ((req_tuser == gcdc_pkg::OP_NEXT) || (req_tuser == gcdc_pkg::OP_PREV))
      |=> rsp_tvalid)
      else $error("single-day step did not answer in one cycle");

endmodule

bind gregorian_calendar_day_counter gcdc_checker u_checker (.*);

// ----- verif/gregorian_calendar_day_counter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_calendar_day_counter_tb
// self-checking bench for the gregorian day counter: a directed table covering
// reset, the calendar limits and rejected loads, then random episodes of a
// load followed by day steps and offsets, scored against a date predictor or
// hand-written results while both stream sides idle and stall at random
// ----------------------------------------------------------------------------
module gregorian_calendar_day_counter_tb;

   import gcdc_pkg::*;

   localparam int LIMIT_CYCLES  = 4000000;
   localparam int RANDOM_ITEMS  = 1330;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_AFTER    = 500;   // results seen before the long receiver hold-off
   localparam int HOLD_CYCLES   = 300;
   localparam int MAX_REPORTS   = 10;
   localparam int LAST_DAY      = int'(MAX_SERIAL);

   // one result of the block
   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [SERIAL_W-1:0] serial;
      status_type          status;
   } cal_date_rsp_type;

   // one request as driven, plus bench bookkeeping
   typedef struct packed {
      op_type              op;
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [OFFSET_W-1:0] offset;
      bit                  typed;        // exp holds a hand-written result
      bit                  drain_first;  // hold back until every result is in
      cal_date_rsp_type    exp;
   } req_item_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]        req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   req_item_type     stim_q[$];
   req_item_type     dir_tbl[$];
   cal_date_rsp_type date_q[$];     // dates still owed by the block, oldest first

   // predicted calendar state, 0001-01-01 out of reset
   int cal_year   = 1;
   int cal_month  = 1;
   int cal_day    = 1;
   int cal_serial = 0;

   int n_errors  = 0;
   int rsp_count = 0;
   int cycle_cnt = 0;

   gregorian_calendar_day_counter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- calendar

   function automatic bit leap_year(input int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int month_days(input int y, input int m);
      case (m)
         2:           return leap_year(y) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:     return 31;
      endcase
   endfunction

   function automatic int date_to_day_number(input int y, input int m, input int d);
      int p, t;
      p = y - 1;
      t = p * 365 + p / 4 - p / 100 + p / 400;
      for (int k = 1; k < m; k++) t += month_days(y, k);
      return t + d - 1;
   endfunction

   // 400-year cycles, then centuries, then 4-year groups, then single years
   function automatic void set_from_day_number(input int n);
      int r, q400, q100, q4, q1, y, m;
      q400 = n / 146097;
      r    = n % 146097;
      q100 = r / 36524;
      if (q100 > 3) q100 = 3;           // last day of a leap century
      r   -= q100 * 36524;
      q4   = r / 1461;
      r    = r % 1461;
      q1   = r / 365;
      if (q1 > 3) q1 = 3;               // last day of a leap year
      r   -= q1 * 365;
      y    = 400 * q400 + 100 * q100 + 4 * q4 + q1 + 1;
      m    = 1;
      while (m < 12 && r >= month_days(y, m)) begin
         r -= month_days(y, m);
         m++;
      end
      cal_year   = y;
      cal_month  = m;
      cal_day    = r + 1;
      cal_serial = n;
   endfunction

   // moves the predicted date for one request and returns the date it reports
   function automatic cal_date_rsp_type apply_request(input req_item_type r);
      int               y, m, d, tgt;
      status_type       st;
      cal_date_rsp_type res;
      y  = int'(r.year);
      m  = int'(r.month);
      d  = int'(r.day);
      st = ST_OK;
      case (r.op)
         OP_LOAD: begin
            if (y < 1 || y > 9999 || m < 1 || m > 12 || d < 1 || d > month_days(y, m)) begin
               st = ST_INVALID;
            end else begin
               cal_year   = y;
               cal_month  = m;
               cal_day    = d;
               cal_serial = date_to_day_number(y, m, d);
            end
         end
         OP_NEXT: begin
            if (cal_serial >= LAST_DAY) st = ST_RANGE;
            else set_from_day_number(cal_serial + 1);
         end
         OP_PREV: begin
            if (cal_serial == 0) st = ST_RANGE;
            else set_from_day_number(cal_serial - 1);
         end
         default: begin
            tgt = cal_serial + int'($signed(r.offset));
            if (tgt < 0) begin
               tgt = 0;
               st  = ST_RANGE;
            end else if (tgt > LAST_DAY) begin
               tgt = LAST_DAY;
               st  = ST_RANGE;
            end
            if (r.offset != '0) set_from_day_number(tgt);
         end
      endcase
      res.year   = YEAR_W'(cal_year);
      res.month  = MONTH_W'(cal_month);
      res.day    = DAY_W'(cal_day);
      res.serial = SERIAL_W'(cal_serial);
      res.status = st;
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic req_item_type dir_row(input op_type op, input int y, input int m,
                                            input int d, input int off);
      req_item_type it;
      it             = '0;
      it.op          = op;
      it.year        = YEAR_W'(y);
      it.month       = MONTH_W'(m);
      it.day         = DAY_W'(d);
      it.offset      = OFFSET_W'(off);
      return it;
   endfunction

   function automatic req_item_type dir_chk(input op_type op, input int y, input int m,
                                            input int d, input int off, input int ey,
                                            input int em, input int ed, input int en,
                                            input status_type est);
      req_item_type it;
      it            = dir_row(op, y, m, d, off);
      it.typed      = 1'b1;
      it.exp.year   = YEAR_W'(ey);
      it.exp.month  = MONTH_W'(em);
      it.exp.day    = DAY_W'(ed);
      it.exp.serial = SERIAL_W'(en);
      it.exp.status = est;
      return it;
   endfunction

   // don't-care fields carry random bits as well
   function automatic req_item_type noise_item(input op_type op);
      req_item_type it;
      it        = '0;
      it.op     = op;
      it.year   = YEAR_W'($urandom_range(0, 16383));
      it.month  = MONTH_W'($urandom_range(0, 15));
      it.day    = DAY_W'($urandom_range(0, 31));
      it.offset = OFFSET_W'($urandom_range(0, 65535));
      return it;
   endfunction

   // years biased towards centuries, leap years and both ends of the range
   function automatic int rand_year();
      case ($urandom_range(0, 5))
         0:       return 100 * $urandom_range(1, 99);
         1:       return 400 * $urandom_range(1, 24);
         2:       return 4 * $urandom_range(1, 2499);
         3:       return $urandom_range(1, 4);
         4:       return 9999 - $urandom_range(0, 3);
         default: return $urandom_range(1, 9999);
      endcase
   endfunction

   task automatic build_directed();
      // after reset: stepping back past 0001-01-01 and a zero offset there
      dir_tbl.push_back(dir_chk(OP_PREV,   0, 0, 0,  0, 1, 1, 1, 0, ST_RANGE));
      dir_tbl.push_back(dir_chk(OP_OFFSET, 0, 0, 0, -1, 1, 1, 1, 0, ST_RANGE));
      dir_tbl.push_back(dir_chk(OP_OFFSET, 0, 0, 0,  0, 1, 1, 1, 0, ST_OK));
      // last representable day, stepping past it is held
      dir_tbl.push_back(dir_chk(OP_LOAD,   9999, 12, 31, 0, 9999, 12, 31, LAST_DAY, ST_OK));
      dir_tbl.push_back(dir_chk(OP_NEXT,   0, 0, 0, 0, 9999, 12, 31, LAST_DAY, ST_RANGE));
      dir_tbl.push_back(dir_chk(OP_OFFSET, 0, 0, 0, 32767, 9999, 12, 31, LAST_DAY, ST_RANGE));
      // rejected loads keep the date
      dir_tbl.push_back(dir_chk(OP_LOAD, 0,     1,  1,  0, 9999, 12, 31, LAST_DAY, ST_INVALID));
      dir_tbl.push_back(dir_chk(OP_LOAD, 10000, 1,  1,  0, 9999, 12, 31, LAST_DAY, ST_INVALID));
      dir_tbl.push_back(dir_chk(OP_LOAD, 16383, 15, 31, 0, 9999, 12, 31, LAST_DAY, ST_INVALID));
      dir_tbl.push_back(dir_chk(OP_LOAD, 2023,  0,  1,  0, 9999, 12, 31, LAST_DAY, ST_INVALID));
      dir_tbl.push_back(dir_chk(OP_LOAD, 2023,  2,  0,  0, 9999, 12, 31, LAST_DAY, ST_INVALID));
      dir_tbl.push_back(dir_chk(OP_LOAD, 2023,  2,  29, 0, 9999, 12, 31, LAST_DAY, ST_INVALID));
      dir_tbl.push_back(dir_chk(OP_LOAD, 1900,  2,  29, 0, 9999, 12, 31, LAST_DAY, ST_INVALID));
      dir_tbl.push_back(dir_chk(OP_LOAD, 2023,  4,  31, 0, 9999, 12, 31, LAST_DAY, ST_INVALID));
      // leap day of a 400-year century, held back until the pipe is empty
      dir_tbl.push_back(dir_row(OP_LOAD, 2000, 2, 29, 0));
      dir_tbl[$].drain_first = 1'b1;
      dir_tbl.push_back(dir_row(OP_NEXT, 0, 0, 0, 0));
      dir_tbl.push_back(dir_row(OP_PREV, 0, 0, 0, 0));
      // year rollover
      dir_tbl.push_back(dir_row(OP_LOAD, 2024, 12, 31, 0));
      dir_tbl.push_back(dir_row(OP_NEXT, 0, 0, 0, 0));
      // first day, most negative offset, then the largest positive one
      dir_tbl.push_back(dir_chk(OP_LOAD,   1, 1, 1, 0, 1, 1, 1, 0, ST_OK));
      dir_tbl.push_back(dir_chk(OP_OFFSET, 0, 0, 0, -32768, 1, 1, 1, 0, ST_RANGE));
      dir_tbl.push_back(dir_row(OP_OFFSET, 0, 0, 0, 32767));
      // offset stopped at the upper limit
      dir_tbl.push_back(dir_row(OP_LOAD, 9999, 12, 1, 0));
      dir_tbl.push_back(dir_chk(OP_OFFSET, 0, 0, 0, 100, 9999, 12, 31, LAST_DAY, ST_RANGE));
      dir_tbl.push_back(dir_row(OP_PREV, 0, 0, 0, 0));
      foreach (dir_tbl[i]) stim_q.push_back(dir_tbl[i]);
   endtask

   // episodes: one load, mostly of an interesting valid date, then day steps
   task automatic build_random();
      req_item_type it;
      int           n, steps, y, m, d, md, sel, mag, offset_cnt;
      n          = 0;
      offset_cnt = 0;
      while (n < RANDOM_ITEMS) begin
         it  = noise_item(OP_LOAD);
         sel = $urandom_range(0, 9);
         if (sel != 0) begin
            y = rand_year();
            case ($urandom_range(0, 3))
               0:       m = 12;
               1:       m = $urandom_range(1, 3);
               default: m = $urandom_range(1, 12);
            endcase
            md = month_days(y, m);
            case ($urandom_range(0, 3))
               0:       d = md;
               1:       d = 1;
               2:       d = md - $urandom_range(0, 2);
               default: d = $urandom_range(1, md);
            endcase
            // broken load: day zero or past the end of the month
            if (sel == 1)
               d = (md == 31 || $urandom_range(0, 1) == 0) ? 0
                                                          : $urandom_range(md + 1, 31);
            it.year  = YEAR_W'(y);
            it.month = MONTH_W'(m);
            it.day   = DAY_W'(d);
         end
         it.drain_first = ($urandom_range(0, 99) == 0);
         stim_q.push_back(it);
         n++;
         steps = $urandom_range(1, 10);
         repeat (steps) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
               it = noise_item(OP_NEXT);
            end else if (sel < 65) begin
               it = noise_item(OP_PREV);
            end else begin
               it = noise_item(OP_OFFSET);
               offset_cnt++;
               // full-range offsets are rare, each walks up to 32k days
               if (offset_cnt % 40 != 0) begin
                  mag       = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 40)
                                                           : $urandom_range(0, 2000);
                  it.offset = $urandom_range(0, 1) ? OFFSET_W'(-mag) : OFFSET_W'(mag);
               end
            end
            stim_q.push_back(it);
            n++;
         end
      end
   endtask

   // ---------------------------------------------------------------- sender

   initial begin : req_source
      req_item_type     cur;
      cal_date_rsp_type prd;
      int               burst_left, gap_left;
      cur        = '0;
      burst_left = 0;
      gap_left   = 0;
      build_directed();
      build_random();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      while (reset) @(posedge clock);
      while (1) begin
         @(posedge clock);
         if (req_tvalid && req_tready) begin
            // request taken at this edge: predict its date now
            prd = apply_request(cur);
            date_q.push_back(cur.typed ? cur.exp : prd);
         end else if (req_tvalid) begin
            continue;                    // still offered, hold every field
         end
         if (stim_q.size() == 0) begin
            req_tvalid <= 1'b0;
            break;
         end
         if (stim_q[0].drain_first && date_q.size() != 0) begin
            req_tvalid <= 1'b0;
            continue;
         end
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
            continue;
         end
         cur = stim_q.pop_front();
         req_tvalid <= 1'b1;
         req_tuser  <= cur.op;
         req_tdata  <= {1'b0, cur.offset, cur.day, cur.month, cur.year};
         if (burst_left <= 1) begin
            // long bursts now and then give stretches with no idling
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 20);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         end else begin
            burst_left--;
         end
      end
      // all requests in: wait for the owed dates, then watch for strays
      while (date_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (n_errors == 0 && date_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // ---------------------------------------------------------------- receiver

   int       hold_left = 0;
   bit       hold_done = 1'b0;
   int       pat_left  = 0;
   logic [7:0] stall_pat = 8'hFF;
   logic [2:0] pat_pos   = '0;

   // stall pattern changes every so often; one long hold-off fills the block
   always @(posedge clock) begin : rsp_sink
      if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && rsp_count >= HOLD_AFTER) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         if (pat_left == 0) begin
            case ($urandom_range(0, 3))
               0:       stall_pat <= 8'hFF;
               1:       stall_pat <= 8'($urandom) & 8'($urandom) | 8'h01;
               default: stall_pat <= 8'($urandom) | 8'h01;
            endcase
            pat_left <= $urandom_range(16, 128);
         end else begin
            pat_left <= pat_left - 1;
         end
         rsp_tready <= stall_pat[pat_pos];
         pat_pos    <= pat_pos + 3'd1;
      end
   end

   // ---------------------------------------------------------------- scoring

   always @(posedge clock) begin : rsp_check
      cal_date_rsp_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.year   = rsp_tdata[13:0];
         got.month  = rsp_tdata[17:14];
         got.day    = rsp_tdata[22:18];
         got.serial = rsp_tdata[44:23];
         got.status = status_type'(rsp_tdata[46:45]);
         rsp_count++;
         if (date_q.size() == 0) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
               $display("result %0d with nothing owed: %0d-%0d-%0d day %0d status %0d",
                        rsp_count, got.year, got.month, got.day, got.serial, got.status);
         end else begin
            want = date_q.pop_front();
            if (got.year !== want.year || got.month !== want.month || got.day !== want.day
                || got.serial !== want.serial || got.status !== want.status) begin
               n_errors++;
               if (n_errors <= MAX_REPORTS)
                  $display("result %0d: want %0d-%0d-%0d/%0d/%0d got %0d-%0d-%0d/%0d/%0d",
                           rsp_count, want.year, want.month, want.day, want.serial,
                           want.status, got.year, got.month, got.day, got.serial,
                           got.status);
            end
         end
      end
   end

   // runaway guard
   always @(posedge clock) begin : watchdog
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= LIMIT_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

endmodule
